FILE: sv/varint_zigzag_decoder_top_macros.svh
// Assertion macros for the varint/zigzag decoder.
// Used by varint_zigzag_decoder_top.sv; depends on nothing.
`ifndef VARINT_ZIGZAG_DECODER_TOP_MACROS_SVH
`define VARINT_ZIGZAG_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define VZZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vzz same-cycle check failed");

// next-cycle implication, disabled during reset
`define VZZ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vzz next-cycle check failed");

`endif

FILE: sv/vzz_pkg.sv
// Types, constants and helper functions for the varint/zigzag decoder.
// No dependencies; imported by every module of the block.
package vzz_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned INDEX_W  = 4;

    localparam int unsigned CONT_BIT = 7;            // bit 7 set: more bytes follow
    localparam logic [6:0]  PAYLOAD_MASK = 7'h7f;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 4'd9;
    localparam logic [INDEX_W-1:0] SAT_INDEX  = 4'd10;

    localparam logic [1:0] WIDTH_16 = 2'd0;
    localparam logic [1:0] WIDTH_32 = 2'd1;
    localparam logic [1:0] WIDTH_64 = 2'd2;

    localparam logic ERR_OK       = 1'b0;
    localparam logic ERR_OVERFLOW = 1'b1;

    typedef struct packed {
        logic [1:0]        result_width;
        logic              signed_value;
        logic [BYTE_W-1:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic               error_code;
        logic [VALUE_W-1:0] value;
    } result_t;

    typedef struct packed {
        logic [INDEX_W-1:0] byte_index;
        logic               term_taken;   // terminator consumed this cycle
    } core_stat_t;

    // place a 7-bit group at bit 7*idx; only bit 0 survives at index 9
    function automatic logic [VALUE_W-1:0] place_payload(input logic [6:0] pl,
                                                         input logic [INDEX_W-1:0] idx);
        logic [VALUE_W-1:0] ext;
        logic [VALUE_W-1:0] res;
        ext = {57'd0, pl & PAYLOAD_MASK};
        case (idx)
            4'd0:    res = ext;
            4'd1:    res = ext << 7;
            4'd2:    res = ext << 14;
            4'd3:    res = ext << 21;
            4'd4:    res = ext << 28;
            4'd5:    res = ext << 35;
            4'd6:    res = ext << 42;
            4'd7:    res = ext << 49;
            4'd8:    res = ext << 56;
            4'd9:    res = ext << 63;
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] width_cut(input logic [VALUE_W-1:0] v,
                                                     input logic [1:0] sel);
        logic [VALUE_W-1:0] res;
        case (sel)
            WIDTH_16: res = {48'd0, v[15:0]};
            WIDTH_32: res = {32'd0, v[31:0]};
            WIDTH_64: res = v;
            default:  res = v;                    // unused code acts as 64 bits
        endcase
        return res;
    endfunction

endpackage

FILE: sv/varint_zigzag_decoder_top.sv
// Varint/zigzag decoder top: input register, decode core, result register.
// A terminating byte's result passes the input and result registers; m_tready stalls delay it.
// Throughput: one byte per cycle unless m_tready stalls a terminator; continuation bytes give no result.
// The accumulator update is one shift-or per byte between the two registers.
// Reset (aresetn low, synchronous) empties both registers and clears the state.
`include "varint_zigzag_decoder_top_macros.svh"
module varint_zigzag_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic [2:0]  s_tuser,    // [0] signed_value, [2:1] result_width
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] value
    output logic [0:0]  m_tuser     // [0] error_code
);
    import vzz_pkg::*;

    in_item_t   s_item;
    in_item_t   item;
    logic       item_valid;
    logic       take;
    logic       res_valid;
    result_t    res;
    core_stat_t stat;
    logic       out_free;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    assign s_item.in_byte      = s_tdata;
    assign s_item.signed_value = s_tuser[0];
    assign s_item.result_width = s_tuser[2:1];

    vzz_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    assign out_free = !out_valid_reg || m_tready;

    vzz_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res),
        .stat       (stat)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.value;
    assign m_tuser[0] = out_reg.error_code;

    `VZZ_ASSERT_IMP(a_ovf_zero, aclk, aresetn, m_tvalid && (m_tuser[0] == ERR_OVERFLOW), m_tdata == 64'd0)
    `VZZ_ASSERT_IMP(a_idx_sat, aclk, aresetn, 1'b1, stat.byte_index <= SAT_INDEX)
    `VZZ_ASSERT_NXT(a_idx_clear, aclk, aresetn, stat.term_taken, stat.byte_index == 4'd0)
    `VZZ_ASSERT_NXT(a_res_loads, aclk, aresetn, stat.term_taken, m_tvalid)

endmodule

FILE: sv/vzz_in_stage.sv
// Input register of the varint/zigzag decoder: holds one accepted byte.
// Depends on vzz_pkg.
module vzz_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  vzz_pkg::in_item_t s_item,
    input  logic              take,      // core consumes the held item
    output logic              item_valid,
    output vzz_pkg::in_item_t item
);
    import vzz_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg;
    logic     load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/vzz_core.sv
// Accumulator, byte index and result logic of the varint/zigzag decoder.
// Depends on vzz_pkg.
module vzz_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  vzz_pkg::in_item_t   item,
    input  logic                out_free,   // result register can load
    output logic                take,
    output logic                res_valid,
    output vzz_pkg::result_t    res,
    output vzz_pkg::core_stat_t stat
);
    import vzz_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               is_cont;
    logic               overflow;
    logic [VALUE_W-1:0] placed;
    logic [VALUE_W-1:0] full;
    logic [VALUE_W-1:0] zz;

    assign is_cont = item.in_byte[CONT_BIT];
    assign placed  = place_payload(item.in_byte[6:0], idx_reg);
    // continuation bytes never need the result slot
    assign take      = item_valid && (is_cont || out_free);
    assign res_valid = take && !is_cont;

    assign overflow = (idx_reg > LAST_INDEX) ||
                      ((idx_reg == LAST_INDEX) && (item.in_byte[6:1] != 6'd0));
    assign full = acc_reg | placed;
    assign zz   = full[0] ? ~(full >> 1) : (full >> 1);

    always_comb begin
        if (overflow) begin
            res.value      = '0;
            res.error_code = ERR_OVERFLOW;
        end else begin
            res.value      = width_cut(item.signed_value ? zz : full, item.result_width);
            res.error_code = ERR_OK;
        end
    end

    always_comb begin
        acc_next = acc_reg;
        idx_next = idx_reg;
        if (take) begin
            if (!is_cont) begin
                acc_next = '0;
                idx_next = '0;
            end else if (idx_reg <= LAST_INDEX) begin
                acc_next = full;
                idx_next = idx_reg + 4'd1;
            end else begin
                idx_next = SAT_INDEX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            idx_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            idx_reg <= idx_next;
        end
    end

    assign stat.byte_index = idx_reg;
    assign stat.term_taken = res_valid;

endmodule

FILE: test/tb.sv
// Self-checking bench for varint_zigzag_decoder_top: directed byte table, then random varints.
// Needs vzz_pkg and the decoder RTL. Expected results come from a shadow decoder in this file or from a table row.
`timescale 1ns / 1ps
module tb;
    import vzz_pkg::*;

    localparam int RANDOM_BYTES = 1950;
    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_PCT     = 13;
    localparam int N_ROWS       = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;      // [7:0] in_byte
    logic [2:0]  s_tuser  = '0;      // [0] signed_value, [2:1] result_width
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // [63:0] value
    logic [0:0]  m_tuser;            // [0] error_code

    varint_zigzag_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // one queued input byte; fixed marks a terminator whose result is typed in the table
    typedef struct {
        in_item_t item;
        bit       fixed;
        result_t  want;
    } byte_stim_t;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        signed_value;
        logic [1:0]  result_width;
        logic [3:0]  reps;
        logic        has_want;
        logic [63:0] want_value;
        logic        want_err;
    } byte_row_t;

    // zero byte, zigzag of an odd value, the full 64-bit value, tenth-byte overflow,
    // and a run past ten bytes (continuation at index 9 and beyond, then a terminator)
    byte_row_t directed_rows [N_ROWS] = '{
        '{8'h00, 1'b0, WIDTH_64, 4'd1,  1'b1, 64'd0,                  ERR_OK},
        '{8'h7f, 1'b1, WIDTH_16, 4'd1,  1'b0, 64'd0,                  ERR_OK},
        '{8'hff, 1'b0, WIDTH_16, 4'd9,  1'b0, 64'd0,                  ERR_OK},
        '{8'h01, 1'b0, 2'd3,     4'd1,  1'b1, 64'hffff_ffff_ffff_ffff, ERR_OK},
        '{8'hff, 1'b1, WIDTH_32, 4'd9,  1'b0, 64'd0,                  ERR_OK},
        '{8'h02, 1'b1, WIDTH_32, 4'd1,  1'b1, 64'd0,                  ERR_OVERFLOW},
        '{8'h80, 1'b0, WIDTH_64, 4'd11, 1'b0, 64'd0,                  ERR_OK},
        '{8'h00, 1'b1, WIDTH_16, 4'd1,  1'b1, 64'd0,                  ERR_OVERFLOW}
    };

    byte_stim_t stim_q[$];
    result_t    pending_results[$];

    logic [63:0] shadow_acc = '0;
    logic [3:0]  shadow_idx = '0;

    int drv_idx   = 0;
    int in_count  = 0;
    int out_count = 0;
    int ovf_count = 0;
    int errors    = 0;

    // no idling on either side while this window of input transfers goes by
    wire quiet = (in_count >= 700) && (in_count < 1100);

    task automatic push_item(input logic [7:0] b, input logic sv, input logic [1:0] rw,
                             input bit fixed, input result_t want);
        byte_stim_t s;
        s.item.in_byte      = b;
        s.item.signed_value = sv;
        s.item.result_width = rw;
        s.fixed             = fixed;
        s.want              = want;
        stim_q.push_back(s);
    endtask

    function automatic logic [6:0] rand_payload();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 7'h7f;
        if (r < 20) return 7'h00;
        return 7'($urandom_range(127));
    endfunction

    // shadow decoder: folds one byte into the state, returns 1 when a value completes
    function automatic bit decode_byte(input in_item_t it, output result_t res);
        logic [63:0] grp;
        logic [63:0] v;
        grp = {57'd0, it.in_byte[6:0]};
        res = '0;
        if (it.in_byte[CONT_BIT]) begin
            if (shadow_idx <= LAST_INDEX) begin
                shadow_acc = shadow_acc | (grp << (7 * shadow_idx));
                shadow_idx = shadow_idx + 4'd1;
            end else begin
                shadow_idx = SAT_INDEX;
            end
            return 1'b0;
        end
        if (shadow_idx > LAST_INDEX || (shadow_idx == LAST_INDEX && it.in_byte > 8'd1)) begin
            res.value      = '0;
            res.error_code = ERR_OVERFLOW;
        end else begin
            v = shadow_acc | (grp << (7 * shadow_idx));
            if (it.signed_value)
                v = v[0] ? ~(v >> 1) : (v >> 1);
            case (it.result_width)
                WIDTH_16: v = {48'd0, v[15:0]};
                WIDTH_32: v = {32'd0, v[31:0]};
                default:  ;
            endcase
            res.value      = v;
            res.error_code = ERR_OK;
        end
        shadow_acc = '0;
        shadow_idx = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < 20)
            $display("[%0t] mismatch on %s: got 0x%016h, expected 0x%016h",
                     $realtime, what, got, want);
        errors++;
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (drv_idx < stim_q.size() && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= stim_q[drv_idx].item.in_byte;
                s_tuser  <= {stim_q[drv_idx].item.result_width,
                             stim_q[drv_idx].item.signed_value};
                drv_idx  <= drv_idx + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : monitor
        in_item_t it;
        result_t  res;
        result_t  want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                out_count <= out_count + 1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result value", m_tdata, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("value", m_tdata, want.value);
                    if (m_tuser[0] !== want.error_code)
                        report_mismatch("error_code", {63'd0, m_tuser[0]},
                                        {63'd0, want.error_code});
                end
            end
            if (s_tvalid && s_tready) begin
                it.in_byte      = s_tdata;
                it.signed_value = s_tuser[0];
                it.result_width = s_tuser[2:1];
                if (decode_byte(it, res)) begin
                    if (stim_q[in_count].fixed)
                        res = stim_q[in_count].want;
                    if (res.error_code == ERR_OVERFLOW)
                        ovf_count <= ovf_count + 1;
                    pending_results.push_back(res);
                end
                in_count <= in_count + 1;
            end
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : sequencer
        int base;
        int kind;
        int len;
        int r;
        logic [7:0] b;
        result_t want;

        for (int i = 0; i < N_ROWS; i++) begin
            want.value      = directed_rows[i].want_value;
            want.error_code = directed_rows[i].want_err;
            for (int k = 0; k < directed_rows[i].reps; k++)
                push_item(directed_rows[i].in_byte, directed_rows[i].signed_value,
                          directed_rows[i].result_width,
                          directed_rows[i].has_want && (k == directed_rows[i].reps - 1),
                          want);
        end

        // mostly well-formed varints with random content; some noise and overlong runs
        want = '0;
        base = stim_q.size();
        while (stim_q.size() - base < RANDOM_BYTES) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                push_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                          2'($urandom_range(3)), 1'b0, want);
            end else begin
                if (kind < 14) begin
                    len = $urandom_range(11, 14);
                end else begin
                    r = $urandom_range(99);
                    if (r < 35)      len = 1;
                    else if (r < 60) len = $urandom_range(2, 3);
                    else if (r < 80) len = $urandom_range(4, 6);
                    else if (r < 92) len = $urandom_range(7, 9);
                    else             len = 10;
                end
                for (int k = 0; k < len - 1; k++)
                    push_item({1'b1, rand_payload()}, 1'($urandom_range(1)),
                              2'($urandom_range(3)), 1'b0, want);
                // the tenth byte only fits 0 or 1; larger values overflow
                if (len == 10 && $urandom_range(3) != 0)
                    b = 8'($urandom_range(1));
                else
                    b = {1'b0, rand_payload()};
                push_item(b, 1'($urandom_range(1)), 2'($urandom_range(3)), 1'b0, want);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (in_count < stim_q.size())
            @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        // terminators still in the two-stage pipe would show up here
        repeat (6) @(posedge aclk);

        $display("Fed %0d bytes (%0d directed), checked %0d results, %0d of them overflow.",
                 in_count, base, out_count, ovf_count);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/vzz_pkg.sv
sv/vzz_in_stage.sv
sv/vzz_core.sv
sv/varint_zigzag_decoder_top.sv
test/tb.sv
